>>> src/clf_pkg.sv
// ----------------------------------------------------------------------------
// clf_pkg: shared definitions for the command line framer
// Sizes of the slot ring and the line buffer, frame kinds, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clf_pkg;

  // Ring and line sizes.
  localparam int QUEUE_SLOTS = 16;
  localparam int MAX_LEN     = 128;
  localparam int SLOT_W      = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int COUNT_W     = $clog2(MAX_LEN);
  localparam int MIN_LINE    = 3;

  // Widths of the ports.
  localparam int BYTE_W      = 8;
  localparam int SLOT_OUT_W  = 4;
  localparam int POS_OUT_W   = 7;
  localparam int LEN_OUT_W   = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [BYTE_W-1:0] TILDE_BYTE  = 8'h7E;
  localparam logic [BYTE_W-1:0] CHAR_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_N      = 8'h4E;
  localparam logic [BYTE_W-1:0] LINE_END_RESET = 8'd10;
  localparam logic [BYTE_W-1:0] CR_RESET       = 8'd13;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_TEXT     = 3'd1,
    KIND_CAN      = 3'd2,
    KIND_TILDE    = 3'd3,
    KIND_UNMARKED = 3'd4,
    KIND_OVERFLOW = 3'd5,
    KIND_SHORT    = 3'd6
  } frame_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_END = 2'd0,
    REG_CR       = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> src/command_line_framer.sv
// ----------------------------------------------------------------------------
// command_line_framer: splits a received byte stream into command lines
// Each byte is echoed with its ring slot and position; closing, dropped and
// overflowing lines are flagged with their kind and length.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction | handshake
//  --------+---------------------------------+-----------+------------------
//  in      | rx_byte                         | in        | in_valid/in_stall
//  out     | slot, position, data_byte,      | out       | out_valid/out_stall
//          | frame_done, frame_kind,         |           |
//          | frame_length                    |           |
//  cfg     | cfg_index, cfg_data             | in        | cfg_valid/cfg_ready
//
// One byte per cycle while the input is not stalled; the result appears in the cycle after the request is taken.
// The framing state is updated at acceptance and the result goes into a single
// output register, so the input is stalled only in a cycle where that register
// is full and the downstream side stalls it.
// Reset (synchronous) clears the slot, count, tilde mark and output valid, and
// restores the terminator registers to line end and carriage return.
`timescale 1ns / 1ps
`default_nettype none

module command_line_framer
  import clf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [BYTE_W-1:0]      rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SLOT_OUT_W-1:0]       slot,
  output logic [POS_OUT_W-1:0]        position,
  output logic [BYTE_W-1:0]           data_byte,
  output logic                        frame_done,
  output frame_kind_t                 frame_kind,
  output logic [LEN_OUT_W-1:0]        frame_length,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data
);

  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(MAX_LEN - 1);
  localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(QUEUE_SLOTS - 1);
  localparam logic [COUNT_W-1:0] MIN_COUNT  = COUNT_W'(MIN_LINE);

  logic [BYTE_W-1:0]  line_end_char;
  logic [BYTE_W-1:0]  carriage_return_char;
  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  write_slot_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic               tilde_marked;
  logic               tilde_marked_next;
  logic [BYTE_W-1:0]  prefix_bytes [MIN_LINE];

  logic               in_fire;
  logic               is_tilde;
  logic               is_term;
  logic               prefix_write;
  logic               done_next;
  frame_kind_t        kind_next;
  logic [LEN_OUT_W-1:0] len_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_fire   = in_valid & ~in_stall;

  assign is_tilde     = (rx_byte == TILDE_BYTE);
  assign is_term      = ~is_tilde &&
                        (rx_byte == carriage_return_char || rx_byte == line_end_char);
  assign prefix_write = ~(is_tilde && byte_count != '0) && ~is_term &&
                        (byte_count < MIN_COUNT);

  always_comb begin
    write_slot_next   = write_slot;
    byte_count_next   = byte_count;
    tilde_marked_next = tilde_marked;
    done_next         = 1'b0;
    kind_next         = KIND_NONE;
    len_next          = '0;
    priority if (is_tilde && byte_count != '0) begin
      kind_next         = tilde_marked ? KIND_TILDE : KIND_UNMARKED;
      len_next          = LEN_OUT_W'(byte_count);
      done_next         = 1'b1;
      write_slot_next   = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      byte_count_next   = '0;
      tilde_marked_next = 1'b0;
    end else if (is_term) begin
      len_next          = LEN_OUT_W'(byte_count);
      done_next         = 1'b1;
      byte_count_next   = '0;
      tilde_marked_next = 1'b0;
      if (byte_count < MIN_COUNT) begin
        kind_next = KIND_SHORT;
      end else begin
        if (prefix_bytes[0] == CHAR_C && prefix_bytes[1] == CHAR_A &&
            prefix_bytes[2] == CHAR_N) begin
          kind_next = KIND_CAN;
        end else begin
          kind_next = KIND_TEXT;
        end
        write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      end
    end else begin
      // A tilde reaching this arm is at position 0 and marks the line.
      if (is_tilde) begin
        tilde_marked_next = 1'b1;
      end
      if (byte_count == LAST_COUNT) begin
        kind_next         = KIND_OVERFLOW;
        len_next          = LEN_OUT_W'(MAX_LEN);
        done_next         = 1'b1;
        write_slot_next   = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
        byte_count_next   = '0;
        tilde_marked_next = 1'b0;
      end else begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_end_char        <= LINE_END_RESET;
      carriage_return_char <= CR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_END: line_end_char        <= cfg_data;
        REG_CR:       carriage_return_char <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      byte_count   <= '0;
      tilde_marked <= 1'b0;
    end else if (in_fire) begin
      write_slot   <= write_slot_next;
      byte_count   <= byte_count_next;
      tilde_marked <= tilde_marked_next;
    end
  end

  // The first bytes of a line are kept for the CAN test at its end.
  always_ff @(posedge clk) begin
    if (in_fire && prefix_write) begin
      prefix_bytes[byte_count[1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot         <= SLOT_OUT_W'(write_slot);
      position     <= POS_OUT_W'(byte_count);
      data_byte    <= rx_byte;
      frame_done   <= done_next;
      frame_kind   <= kind_next;
      frame_length <= len_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_command_line_framer.sv
// ----------------------------------------------------------------------------
// tb_command_line_framer: self-checking testbench for the command line framer
// Drives received bytes through the valid/stall input channel and compares
// every echoed byte, slot, position and frame event against a predictor that
// tracks the framing state and the terminator registers. Directed lines cover
// short, text, CAN, tilde, unmarked and overflow frames and unusual
// terminator settings; random lines then run under shifting idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_command_line_framer;
  import clf_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS  = 480;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic [POS_OUT_W-1:0]  position;
    logic [BYTE_W-1:0]     data;
    logic                  done;
    frame_kind_t           kind;
    logic [LEN_OUT_W-1:0]  length;
  } frame_echo_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      rx_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SLOT_OUT_W-1:0]  slot;
  logic [POS_OUT_W-1:0]   position;
  logic [BYTE_W-1:0]      data_byte;
  logic                   frame_done;
  frame_kind_t            frame_kind;
  logic [LEN_OUT_W-1:0]   frame_length;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]      cfg_data = '0;

  command_line_framer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot         (slot),
    .position     (position),
    .data_byte    (data_byte),
    .frame_done   (frame_done),
    .frame_kind   (frame_kind),
    .frame_length (frame_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: terminator registers and the framing of the current line.
  logic [BYTE_W-1:0] term_le = LINE_END_RESET;
  logic [BYTE_W-1:0] term_cr = CR_RESET;
  int                line_slot = 0;
  int                line_count = 0;
  logic [BYTE_W-1:0] line_head [0:2] = '{default: '0};
  logic              line_marked = 1'b0;

  frame_echo_t pending_frames [$];
  int          fail_count = 0;
  int          sent_total = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;

  function automatic frame_echo_t frame_for_byte(input logic [BYTE_W-1:0] b);
    frame_echo_t r;
    r.slot     = SLOT_OUT_W'(line_slot);
    r.position = POS_OUT_W'(line_count);
    r.data     = b;
    r.done     = 1'b0;
    r.kind     = KIND_NONE;
    r.length   = '0;
    if (b == TILDE_BYTE && line_count != 0) begin
      r.kind   = line_marked ? KIND_TILDE : KIND_UNMARKED;
      r.length = LEN_OUT_W'(line_count);
      r.done   = 1'b1;
      line_slot   = (line_slot + 1) % QUEUE_SLOTS;
      line_count  = 0;
      line_marked = 1'b0;
    end else if (b != TILDE_BYTE && (b == term_cr || b == term_le)) begin
      r.length = LEN_OUT_W'(line_count);
      r.done   = 1'b1;
      if (line_count < MIN_LINE) begin
        r.kind = KIND_SHORT;
      end else begin
        if (line_head[0] == CHAR_C && line_head[1] == CHAR_A && line_head[2] == CHAR_N)
          r.kind = KIND_CAN;
        else
          r.kind = KIND_TEXT;
        line_slot = (line_slot + 1) % QUEUE_SLOTS;
      end
      line_count  = 0;
      line_marked = 1'b0;
    end else begin
      // Only a leading tilde can get here, since a later one closes the line.
      if (b == TILDE_BYTE)
        line_marked = 1'b1;
      if (line_count < MIN_LINE)
        line_head[line_count] = b;
      line_count++;
      if (line_count >= MAX_LEN) begin
        r.kind   = KIND_OVERFLOW;
        r.length = LEN_OUT_W'(line_count);
        r.done   = 1'b1;
        line_slot   = (line_slot + 1) % QUEUE_SLOTS;
        line_count  = 0;
        line_marked = 1'b0;
      end
    end
    return r;
  endfunction

  // A byte that leaves the line open, except now and then a fully random one.
  function automatic logic [BYTE_W-1:0] body_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    if ($urandom_range(29) != 0) begin
      while (b == TILDE_BYTE || b == term_le || b == term_cr)
        b = BYTE_W'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    pending_frames.push_back(frame_for_byte(b));
    sent_total++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // Lowers the request and waits until every predicted frame echo has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    if (idx == REG_LINE_END)
      term_le = val;
    else if (idx == REG_CR)
      term_cr = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_line();
    int n;
    logic [BYTE_W-1:0] stop;
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(BYTE_W'($urandom_range(255)));
    end else begin
      n = ($urandom_range(99) == 0) ? $urandom_range(MAX_LEN - 3, MAX_LEN + 2)
                                    : $urandom_range(12);
      if ($urandom_range(3) == 0) begin
        send_byte(TILDE_BYTE);
      end else if ($urandom_range(2) == 0) begin
        send_byte(CHAR_C);
        send_byte(CHAR_A);
        send_byte(($urandom_range(3) == 0) ? body_byte() : CHAR_N);
      end
      repeat (n) send_byte(body_byte());
      case ($urandom_range(2))
        0: stop = term_cr;
        1: stop = term_le;
        default: stop = TILDE_BYTE;
      endcase
      send_byte(stop);
    end
  endtask

  task automatic test_short_and_text_lines();
    send_byte(LINE_END_RESET);
    send_text("A");
    send_byte(CR_RESET);
    send_text("CA");
    send_byte(LINE_END_RESET);
    send_text("CAN");
    send_byte(CR_RESET);
    send_text("CAT");
    send_byte(LINE_END_RESET);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CR_RESET);
  endtask

  task automatic test_tilde_frames();
    send_text("~ab~");
    send_text("ab~");
    send_text("~~");
    send_text("~");
    send_byte(LINE_END_RESET);
    send_text("xy~");
  endtask

  task automatic test_overflow();
    send_byte(TILDE_BYTE);
    repeat (MAX_LEN - 1) send_byte(body_byte());
    // The overflow cleared the mark, so this close is unmarked.
    send_text("ab~");
    repeat (MAX_LEN) send_byte(body_byte());
    send_byte(LINE_END_RESET);
  endtask

  task automatic test_terminator_registers();
    wait_idle();
    write_reg(REG_LINE_END, TILDE_BYTE);
    write_reg(REG_CR, 8'h00);
    send_text("abc");
    send_byte(8'h00);
    send_text("ab~");
    send_text("~x~");
    wait_idle();
    write_reg(REG_LINE_END, 8'hFF);
    write_reg(REG_CR, 8'hFF);
    send_text("CAN");
    send_byte(8'hFF);
    send_byte(8'hFF);
    wait_idle();
    // Writes to unused indexes must leave both terminators alone.
    write_reg(REG_SPARE_LO, 8'h55);
    write_reg(REG_SPARE_HI, 8'hAA);
    send_text("abc");
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'hFF);
    wait_idle();
    write_reg(REG_LINE_END, LINE_END_RESET);
    write_reg(REG_CR, CR_RESET);
  endtask

  task automatic test_backpressure();
    int start;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    start = sent_total;
    while (sent_total - start < 40)
      send_random_line();
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int start;
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 45;
          write_reg(REG_LINE_END, BYTE_W'($urandom_range(255)));
          write_reg(REG_CR, BYTE_W'($urandom_range(255)));
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 38;
          write_reg(CFG_INDEX_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
          write_reg(REG_CR, BYTE_W'($urandom_range(255)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(REG_LINE_END, LINE_END_RESET);
          write_reg(REG_CR, CR_RESET);
        end
      endcase
      start = sent_total;
      while (sent_total - start < PHASE_ITEMS)
        send_random_line();
    end
  endtask

  // Receiver: random stalls, or a long hold when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_echo_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("frame echo with no request pending: data_byte %0d", data_byte);
        fail_count++;
      end else begin
        e = pending_frames.pop_front();
        check_field("slot", e.slot, slot);
        check_field("position", e.position, position);
        check_field("data_byte", e.data, data_byte);
        check_field("frame_done", e.done, frame_done);
        check_field("frame_kind", e.kind, frame_kind);
        check_field("frame_length", e.length, frame_length);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 45;
    test_short_and_text_lines();
    test_tilde_frames();
    test_overflow();
    test_terminator_registers();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
src/clf_pkg.sv
src/command_line_framer.sv
tb/tb_command_line_framer.sv
